// ===== design/bvm_pkg.sv =====
// Shared widths, constants and register codes for the battery voltage monitor.
package bvm_pkg;

  localparam int WINDOW   = 10;
  localparam int IDX_W    = $clog2(WINDOW);

  localparam int SAMPLE_W = 12;
  localparam int SUM_W    = 16;
  localparam int THR_W    = 12;
  localparam int LIMIT_W  = 8;
  localparam int SCALE_W  = 16;
  localparam int VOLT_W   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [THR_W-1:0]   THR_RESET   = THR_W'(1100);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(250);
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2330);

  // sum * scale, then divide by 4096 (shift) and by WINDOW (reciprocal multiply)
  localparam int PROD_W  = SUM_W + SCALE_W;
  localparam int ADC_SH  = 12;
  localparam int DIVIN_W = PROD_W - ADC_SH;
  localparam int REC_K   = 24;
  localparam int REC_W   = 24;
  localparam logic [REC_W-1:0] REC_M = REC_W'((2**REC_K + WINDOW - 1) / WINDOW);
  localparam int RPROD_W = DIVIN_W + REC_W;
  localparam int QUOT_W  = DIVIN_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOW_THRESHOLD = 2'd0,
    CFG_COUNT_LIMIT   = 2'd1,
    CFG_SCALE_FACTOR  = 2'd2
  } cfg_idx_e;

endpackage

// ===== design/bvm_window.sv =====
// Sample ring and running window sum; the sum register doubles as the first pipeline stage.
module bvm_window
  import bvm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [SUM_W-1:0]    sum_o
);

  logic [SAMPLE_W-1:0] ring_q [WINDOW];
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                valid_q;
  logic                accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign sum_d = sum_q - SUM_W'(ring_q[idx_q]) + SUM_W'(sample_i);
  assign idx_d = (idx_q == IDX_W'(WINDOW - 1)) ? '0 : idx_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring_q[i] <= '0;
      end
      idx_q   <= '0;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        ring_q[idx_q] <= sample_i;
        idx_q         <= idx_d;
        sum_q         <= sum_d;
      end
    end
  end

  assign out_valid_o = valid_q;
  assign sum_o       = sum_q;

endmodule

// ===== design/bvm_scale.sv =====
// Two stages: sum times scale, then divide by 4096 (shift) and by WINDOW (reciprocal multiply).
module bvm_scale
  import bvm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SUM_W-1:0]   sum_i,
  input  logic [SCALE_W-1:0] scale_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [QUOT_W-1:0]  quot_o
);

  logic [PROD_W-1:0]  prod_q;
  logic               prod_valid_q;
  logic               prod_ready;
  logic [RPROD_W-1:0] rprod;
  logic [QUOT_W-1:0]  quot_q;
  logic               quot_valid_q;

  assign prod_ready = !quot_valid_q || out_ready_i;
  assign in_ready_o = !prod_valid_q || prod_ready;

  // error of the rounded-up reciprocal stays below one step for any DIVIN_W-bit input
  assign rprod = RPROD_W'(prod_q[PROD_W-1:ADC_SH]) * RPROD_W'(REC_M);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      quot_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        prod_valid_q <= in_valid_i;
      end
      if (prod_ready) begin
        quot_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      prod_q <= PROD_W'(sum_i) * PROD_W'(scale_i);
    end
    if (prod_ready && prod_valid_q) begin
      quot_q <= rprod[REC_K +: QUOT_W];
    end
  end

  assign out_valid_o = quot_valid_q;
  assign quot_o      = quot_q;

endmodule

// ===== design/bvm_debounce.sv =====
// Saturation, low-voltage run counter and the result register.
module bvm_debounce
  import bvm_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [QUOT_W-1:0]  quot_i,
  input  logic [THR_W-1:0]   low_threshold_i,
  input  logic [LIMIT_W-1:0] count_limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [VOLT_W-1:0]  volts_o,
  output logic               low_power_o
);

  logic [VOLT_W-1:0]  volts;
  logic [LIMIT_W-1:0] cnt_q, cnt_d;
  logic               valid_q;
  logic [VOLT_W-1:0]  volts_q;
  logic               low_power_q;
  logic               accept;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign volts = (quot_i[QUOT_W-1:VOLT_W] != '0) ? '1 : quot_i[VOLT_W-1:0];

  always_comb begin
    if (volts < VOLT_W'(low_threshold_i)) begin
      // a limit lowered below the count snaps the count to it
      cnt_d = (cnt_q >= count_limit_i) ? count_limit_i : cnt_q + 1'b1;
    end else begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (accept) begin
        cnt_q <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      volts_q     <= volts;
      low_power_q <= (cnt_d == count_limit_i);
    end
  end

  assign out_valid_o = valid_q;
  assign volts_o     = volts_q;
  assign low_power_o = low_power_q;

endmodule

// ===== design/battery_voltage_monitor.sv =====
// Battery voltage monitor: moving average of ADC samples with a debounced low flag.
//
// Input stream: one 12-bit raw ADC sample per request on s_axis. Output stream:
// the averaged voltage in centivolts (saturated at 65535) and the low_power flag
// on m_axis, exactly one result per sample, in order.
// Configuration: cfg_we_i writes cfg_wdata_i into the register selected by
// cfg_idx_i (0 low threshold, 1 count limit, 2 scale factor); other indexes are
// ignored. Write only while the pipeline is empty.
// Pipeline: four register stages, the first loaded at the edge that takes its sample
// (window sum, scale multiply, reciprocal divide, threshold/counter stage), each
// registered in turn. Throughput: one sample per cycle while m_axis_tready does
// not hold the pipeline; the running sum is updated as each sample is taken.
// Reset clears the sample ring, the window sum, the ring index, the low counter
// and all pipeline valids, and loads the register defaults (1100, 250, 2330).
// The first WINDOW-1 results therefore average in zeros.
// When m_axis_tready is low, the result holds and the pipeline keeps filling its
// empty stages; s_axis_tready drops only once every stage holds a request.
module battery_voltage_monitor
  import bvm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // [11:0] adc_sample
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [23:0]           m_axis_tdata   // [15:0] voltage_centivolts, [16] low_power
);

  logic [THR_W-1:0]   low_threshold_q;
  logic [LIMIT_W-1:0] count_limit_q;
  logic [SCALE_W-1:0] scale_factor_q;

  logic               sum_valid, sum_ready;
  logic [SUM_W-1:0]   sum;
  logic               quot_valid, quot_ready;
  logic [QUOT_W-1:0]  quot;
  logic [VOLT_W-1:0]  volts;
  logic               low_power;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_threshold_q <= THR_RESET;
      count_limit_q   <= LIMIT_RESET;
      scale_factor_q  <= SCALE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LOW_THRESHOLD: low_threshold_q <= cfg_wdata_i[THR_W-1:0];
        CFG_COUNT_LIMIT:   count_limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_SCALE_FACTOR:  scale_factor_q  <= cfg_wdata_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  bvm_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .sample_i    (s_axis_tdata[SAMPLE_W-1:0]),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .sum_o       (sum)
  );

  bvm_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .sum_i       (sum),
    .scale_i     (scale_factor_q),
    .out_valid_o (quot_valid),
    .out_ready_i (quot_ready),
    .quot_o      (quot)
  );

  bvm_debounce u_debounce (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (quot_valid),
    .in_ready_o      (quot_ready),
    .quot_i          (quot),
    .low_threshold_i (low_threshold_q),
    .count_limit_i   (count_limit_q),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .volts_o         (volts),
    .low_power_o     (low_power)
  );

  assign m_axis_tdata = {7'd0, low_power, volts};

endmodule

// ===== sim/battery_voltage_monitor_tb.sv =====
// Self-checking testbench for the battery voltage monitor: averaging, debounce, stalls.
`timescale 1ns / 1ps

module battery_voltage_monitor_tb;
  import bvm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // no register behind this index
  localparam int PIPE_CYCLES = 8;      // extra clocks waited after the last expected reading is taken
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int PHASES = 12;
  localparam int PHASE_ITEMS = 90;

  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic              low_power;
  } reading_t;

  typedef enum logic {RX_ALWAYS, RX_PATTERN} rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata = '0;   // [11:0] adc_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;        // [15:0] voltage_centivolts, [16] low_power

  battery_voltage_monitor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: sample window, running sum, low-run counter, register copies
  logic [SAMPLE_W-1:0] window_samples [WINDOW];
  int unsigned         window_pos;
  logic [SUM_W-1:0]    window_total;
  logic [LIMIT_W-1:0]  low_run;
  logic [THR_W-1:0]    thr_reg;
  logic [LIMIT_W-1:0]  limit_reg;
  logic [SCALE_W-1:0]  scale_reg;

  reading_t pending_readings [$];

  int error_count = 0;
  int samples_sent = 0;
  int reg_writes = 0;
  int readings_checked = 0;
  int low_flags_seen = 0;

  // Stimulus pacing, written by the test sequence only
  logic     tx_gaps = 1'b0;
  int       burst_left = 0;
  rx_mode_e rx_mode = RX_ALWAYS;
  int       hold_len = 0;
  int       hold_seq = 0;

  // Receiver-side pacing state
  int   hold_seen = 0;
  int   hold_left = 0;
  int   rx_run_left = 0;
  logic rx_level = 1'b1;

  function automatic int clamp12(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  task automatic reset_predictor();
    foreach (window_samples[i]) window_samples[i] = '0;
    window_pos   = 0;
    window_total = '0;
    low_run      = '0;
    thr_reg      = THR_RESET;
    limit_reg    = LIMIT_RESET;
    scale_reg    = SCALE_RESET;
  endtask

  task automatic average_and_debounce(input logic [SAMPLE_W-1:0] smp);
    logic [63:0] quot;
    reading_t    r;
    window_total = window_total - SUM_W'(window_samples[window_pos]) + SUM_W'(smp);
    window_samples[window_pos] = smp;
    window_pos = (window_pos == WINDOW - 1) ? 0 : window_pos + 1;
    quot = (64'(window_total) * 64'(scale_reg)) / 64'(4096 * WINDOW);
    r.volt = (quot > 64'hFFFF) ? 16'hFFFF : quot[15:0];
    if (r.volt < VOLT_W'(thr_reg)) begin
      // counter holds at the limit, also when the limit was lowered under it
      if (low_run >= limit_reg) low_run = limit_reg;
      else low_run = low_run + 1'b1;
    end else begin
      low_run = '0;
    end
    r.low_power = (low_run == limit_reg);
    pending_readings.push_back(r);
  endtask

  // Called just after a rising edge; returns just after a rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LOW_THRESHOLD: thr_reg = val[THR_W-1:0];
      CFG_COUNT_LIMIT:   limit_reg = val[LIMIT_W-1:0];
      CFG_SCALE_FACTOR:  scale_reg = val[SCALE_W-1:0];
      default: ;
    endcase
    reg_writes++;
    @(posedge clk_i);
  endtask

  // valid stays high into the next call while a burst goes on
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp);
    s_axis_tdata  <= 16'(smp);
    s_axis_tvalid <= 1'b1;
    do @(negedge clk_i); while (!s_axis_tready);
    @(posedge clk_i);
    average_and_debounce(smp);
    samples_sent++;
    if (tx_gaps) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(0, 15);
      end
    end
  endtask

  task automatic drain_readings();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (PIPE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [SAMPLE_W-1:0] battery_sample(int level, int jitter);
    return SAMPLE_W'(clamp12(level + int'($urandom_range(0, 2 * jitter)) - jitter));
  endfunction

  // Receiver: free running, run-length stall pattern, or a counted hold-off
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_mode == RX_ALWAYS) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_run_left == 0) begin
        rx_level    = ~rx_level;
        rx_run_left = rx_level ? $urandom_range(1, 10) : $urandom_range(1, 5);
      end
      rx_run_left--;
      m_axis_tready <= rx_level;
    end
  end

  // Outputs are stable from the falling edge to the accepting rising edge
  always @(negedge clk_i) begin : check_readings
    reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_readings.size() == 0) begin
        $error("reading with nothing expected: volt=%0d low_power=%0b",
               m_axis_tdata[15:0], m_axis_tdata[16]);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        if (m_axis_tdata[15:0] !== want.volt) begin
          $error("voltage_centivolts: expected %0d, got %0d", want.volt, m_axis_tdata[15:0]);
          error_count++;
        end
        if (m_axis_tdata[16] !== want.low_power) begin
          $error("low_power: expected %0b, got %0b", want.low_power, m_axis_tdata[16]);
          error_count++;
        end
        readings_checked++;
        if (want.low_power) low_flags_seen++;
      end
    end
  end

  // Reset defaults; ring still holds zeros so the average ramps up.
  task automatic test_sample_extremes();
    tx_gaps = 1'b0;
    rx_mode = RX_ALWAYS;
    send_sample(12'h000);
    send_sample(12'hFFF);
    send_sample(12'hAAA);
    send_sample(12'h555);
    drain_readings();
  endtask

  task automatic test_low_debounce();
    write_reg(CFG_LOW_THRESHOLD, 16'd0);     // nothing is low: counter clears
    write_reg(CFG_COUNT_LIMIT, 16'd3);
    send_sample(12'd2000);
    drain_readings();
    write_reg(CFG_LOW_THRESHOLD, 16'd4095);  // everything is low
    repeat (4) send_sample(12'd1500);
    drain_readings();
    write_reg(CFG_COUNT_LIMIT, 16'd1);       // limit dropped under the running count
    send_sample(12'd1500);
    drain_readings();
    write_reg(CFG_COUNT_LIMIT, 16'd0);       // zero limit: flag on every reading
    send_sample(12'd1500);
    drain_readings();
    write_reg(CFG_LOW_THRESHOLD, 16'd0);
    send_sample(12'd1500);
    drain_readings();
    write_reg(CFG_COUNT_LIMIT, 16'(LIMIT_RESET));
    write_reg(CFG_LOW_THRESHOLD, 16'(THR_RESET));
  endtask

  task automatic test_scale_extremes();
    write_reg(CFG_SCALE_FACTOR, 16'd0);
    send_sample(12'hFFF);
    drain_readings();
    write_reg(CFG_SCALE_FACTOR, 16'hFFFF);
    send_sample(12'hFFF);
    send_sample(12'hFFF);
    drain_readings();
    write_reg(CFG_SCALE_FACTOR, 16'd1);
    send_sample(12'hFFF);
    drain_readings();
    write_reg(CFG_UNUSED, 16'hFFFF);         // must leave all registers alone
    send_sample(12'd3000);
    drain_readings();
    write_reg(CFG_SCALE_FACTOR, 16'(SCALE_RESET));
  endtask

  // Long receiver hold-off with the sender pushing: input side must back up.
  task automatic test_backpressure();
    tx_gaps  = 1'b0;
    rx_mode  = RX_ALWAYS;
    hold_len = 100;
    hold_seq = hold_seq + 1;
    repeat (40) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
    drain_readings();
  endtask

  task automatic test_random_phases();
    int level;
    int jitter;
    int thr;
    int lim;
    int scl;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin thr = 4095; lim = 255; scl = 65535; end
        1: begin thr = 0;    lim = 1;   scl = 1;     end
        default: begin
          case ($urandom_range(0, 5))
            0:       scl = 0;
            1:       scl = 65535;
            2:       scl = $urandom_range(1, 65535);
            default: scl = $urandom_range(1500, 3500);
          endcase
          lim = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 12);
        end
      endcase
      level = $urandom_range(0, 4095);
      if (phase > 1) begin
        // put the threshold near the steady-state reading so the flag toggles
        thr = clamp12(level * scl / 4096 + int'($urandom_range(0, 60)) - 30);
        if ($urandom_range(0, 5) == 0) thr = $urandom_range(0, 4095);
      end
      write_reg(CFG_SCALE_FACTOR, CFG_DATA_W'(scl));
      write_reg(CFG_COUNT_LIMIT, CFG_DATA_W'(lim));
      write_reg(CFG_LOW_THRESHOLD, CFG_DATA_W'(thr));
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
      rx_mode = ($urandom_range(0, 2) == 0) ? RX_ALWAYS : RX_PATTERN;
      tx_gaps = ($urandom_range(0, 3) != 0);
      jitter  = $urandom_range(0, 150);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 9) == 0) level = clamp12(level + int'($urandom_range(0, 200)) - 100);
        if ($urandom_range(0, 4) == 0) send_sample(SAMPLE_W'($urandom_range(0, 4095)));
        else send_sample(battery_sample(level, jitter));
      end
      drain_readings();
    end
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("timeout with %0d readings outstanding", pending_readings.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    reset_predictor();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_sample_extremes();
    test_low_debounce();
    test_scale_extremes();
    test_backpressure();
    test_random_phases();
    drain_readings();

    $display("Sent %0d ADC samples over %0d register writes, incl. zero/full scale and limits",
             samples_sent, reg_writes);
    $display("Checked %0d readings (%0d with low_power), with bursts, stalls and a long hold-off",
             readings_checked, low_flags_seen);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
